/* sv/sobel_pkg.sv */
// Shared types and constants for the Sobel line edge filter.
package sobel_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MODE     = 2'd1;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int LINE_W  = 11;
    localparam int MIN_LINE_WIDTH = 3;
    localparam int DEFAULT_LINE_WIDTH = 640;

    // Output queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Result flags carried with a pixel from accept to the kernel stage
    typedef struct packed {
        logic emit_pixel;   // a filtered result for column c-1
        logic compute;      // full window available, run the kernel
        logic emit_end;     // the extra last-column result with line_end
    } t_s1_flags;

endpackage

/* sv/sobel_line_edge_filter.sv */
// Sobel 3x3 edge filter on a raster pixel stream, one row of lag.
// Throughput: one pixel per cycle, set by the single read and write port of each line store.
// A result is valid once its pixel has passed the stage 1 registers into the output queue.
// Past the first row a line's last pixel gives two results; input stalls while the output
// queue holds more than two results. Synchronous active-low reset clears control state and
// restores line_width 640, x_mode 1; line stores are not cleared and need no clearing pass.
module sobel_line_edge_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel input
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [sobel_pkg::PIX_W-1:0]        i_pixel_in,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sobel_pkg::PIX_W-1:0]        o_pixel_out,
    output logic                               o_line_end,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sobel_pkg::LINE_W-1:0]       i_cfg_data
);

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (AW + 1 > sobel_pkg::LINE_W) ? AW + 1 : sobel_pkg::LINE_W;
    localparam int PW    = sobel_pkg::PIX_W;

    // Configuration registers
    logic [sobel_pkg::LINE_W-1:0] r_line_width;
    logic                         r_x_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= sobel_pkg::LINE_W'(sobel_pkg::DEFAULT_LINE_WIDTH);
            r_x_mode     <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sobel_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_data;
                sobel_pkg::CFG_X_MODE:     r_x_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- accept stage ----------------
    logic [sobel_pkg::LINE_W-1:0] r_col;
    logic [1:0]                   r_row_phase;
    logic                         r_s1_valid;
    logic                         s1_adv;
    logic                         accept;

    logic [CMP_W-1:0] lw_ext, w_eff, col_ext;
    logic [AW-1:0]    rd_idx;
    logic             last;
    sobel_pkg::t_s1_flags s0_flags;

    always_comb begin
        lw_ext  = CMP_W'(r_line_width);
        col_ext = CMP_W'(r_col);
        // out-of-range widths clamp to the legal span
        if (lw_ext < CMP_W'(sobel_pkg::MIN_LINE_WIDTH)) begin
            w_eff = CMP_W'(sobel_pkg::MIN_LINE_WIDTH);
        end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = lw_ext;
        end
        rd_idx = (col_ext < CMP_W'(MAX_WIDTH)) ? col_ext[AW-1:0] : AW'(MAX_WIDTH - 1);
        last   = (col_ext >= w_eff - CMP_W'(1));
        s0_flags.emit_pixel = (r_row_phase != 2'd0) && (r_col != '0);
        s0_flags.compute    = (r_row_phase == 2'd2) && (r_col >= sobel_pkg::LINE_W'(2));
        s0_flags.emit_end   = (r_row_phase != 2'd0) && last;
    end

    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // Column advances at each input transaction, row phase at each line end until it reaches 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row_phase <= 2'd0;
        end else if (accept) begin
            if (last) begin
                r_col <= '0;
                if (r_row_phase != 2'd2) begin
                    r_row_phase <= r_row_phase + 2'd1;
                end
            end else begin
                r_col <= r_col + sobel_pkg::LINE_W'(1);
            end
        end
    end

    // Stage 1 holding registers
    logic [PW-1:0]        r_s1_pix;
    logic [AW-1:0]        r_s1_idx;
    sobel_pkg::t_s1_flags r_s1_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept || (r_s1_valid && !s1_adv);
        end
        if (accept) begin
            r_s1_pix   <= i_pixel_in;
            r_s1_idx   <= rd_idx;
            r_s1_flags <= s0_flags;
        end
    end

    // ---------------- line stores ----------------
    // Read at accept, written back as the pixel leaves stage 1; consecutive pixels never
    // share a column, so a write never meets a read of the same entry.
    logic [PW-1:0] upper_rd, middle_rd;

    sobel_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (middle_rd),
        .i_rd_en   (accept),
        .i_rd_addr (rd_idx),
        .o_rd_data (upper_rd)
    );

    sobel_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (r_s1_pix),
        .i_rd_en   (accept),
        .i_rd_addr (rd_idx),
        .o_rd_data (middle_rd)
    );

    // ---------------- kernel stage ----------------
    // r_win[0..2]: left column (upper, middle, lower); r_win[3..5]: centre column
    logic [PW-1:0] r_win [6];
    logic [PW+1:0] pos_sum, neg_sum;
    logic signed [PW+2:0] diff, mag;
    logic [PW-1:0] sobel_val;

    always_comb begin
        if (r_x_mode) begin
            pos_sum = (PW+2)'(upper_rd) + {1'b0, middle_rd, 1'b0} + (PW+2)'(r_s1_pix);
            neg_sum = (PW+2)'(r_win[0]) + {1'b0, r_win[1], 1'b0} + (PW+2)'(r_win[2]);
        end else begin
            pos_sum = (PW+2)'(r_win[2]) + {1'b0, r_win[5], 1'b0} + (PW+2)'(r_s1_pix);
            neg_sum = (PW+2)'(r_win[0]) + {1'b0, r_win[3], 1'b0} + (PW+2)'(upper_rd);
        end
        diff = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});
        // X mode takes the magnitude, Y mode floors negatives at zero
        if (diff < 0) begin
            mag = r_x_mode ? -diff : '0;
        end else begin
            mag = diff;
        end
        sobel_val = (mag > (PW+3)'(255)) ? PW'(255) : mag[PW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_adv) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= upper_rd;
            r_win[4] <= middle_rd;
            r_win[5] <= r_s1_pix;
        end
    end

    // ---------------- output queue ----------------
    logic [PW-1:0]                 r_q_pix [sobel_pkg::Q_DEPTH];
    logic                          r_q_end [sobel_pkg::Q_DEPTH];
    logic [sobel_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [sobel_pkg::Q_CNT_W-1:0] r_q_cnt;
    logic [sobel_pkg::Q_CNT_W-1:0] n_q_cnt;
    logic [sobel_pkg::Q_PTR_W-1:0] n_wr_ptr;
    logic [sobel_pkg::Q_PTR_W-1:0] end_ptr;
    logic [1:0]                    push_n;
    logic                          pop;

    // Room for two results is needed before a pixel leaves the kernel stage
    assign s1_adv = r_s1_valid && (r_q_cnt <= sobel_pkg::Q_CNT_W'(sobel_pkg::Q_DEPTH - 2));
    assign pop    = o_out_valid && i_out_ready;

    always_comb begin
        push_n = 2'd0;
        if (s1_adv) begin
            push_n = {1'b0, r_s1_flags.emit_pixel} + {1'b0, r_s1_flags.emit_end};
        end
        n_q_cnt  = r_q_cnt + sobel_pkg::Q_CNT_W'(push_n)
                   - sobel_pkg::Q_CNT_W'(pop);
        n_wr_ptr = r_wr_ptr + sobel_pkg::Q_PTR_W'(push_n);
        end_ptr  = r_s1_flags.emit_pixel ? r_wr_ptr + sobel_pkg::Q_PTR_W'(1) : r_wr_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_q_cnt  <= n_q_cnt;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + sobel_pkg::Q_PTR_W'(1);
            end
        end
        // result for the previous column, then the last-column marker
        if (s1_adv && r_s1_flags.emit_pixel) begin
            r_q_pix[r_wr_ptr] <= r_s1_flags.compute ? sobel_val : '0;
            r_q_end[r_wr_ptr] <= 1'b0;
        end
        if (s1_adv && r_s1_flags.emit_end) begin
            r_q_pix[end_ptr] <= '0;
            r_q_end[end_ptr] <= 1'b1;
        end
    end

    assign o_out_valid = (r_q_cnt != '0);
    assign o_pixel_out = r_q_pix[r_rd_ptr];
    assign o_line_end  = r_q_end[r_rd_ptr];

endmodule

/* sv/sobel_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, and read data held while the read is not enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* tb/sobel_line_edge_filter_check.sv */
// Channel monitor, Sobel line filter predictor and result comparison for the edge filter.
module sobel_line_edge_filter_check #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [sobel_pkg::PIX_W-1:0]        i_pixel_in,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [sobel_pkg::PIX_W-1:0]        i_pixel_out,
    input  logic                               i_line_end,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sobel_pkg::LINE_W-1:0]       i_cfg_data,
    output int                                 o_err_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [sobel_pkg::PIX_W-1:0] pixel;
        logic                        line_end;
    } t_result;

    // results still owed by the block, oldest first
    t_result expected_q[$];

    // predictor state
    logic [sobel_pkg::PIX_W-1:0]  upper_row  [MAX_WIDTH];
    logic [sobel_pkg::PIX_W-1:0]  middle_row [MAX_WIDTH];
    logic [sobel_pkg::PIX_W-1:0]  win [6];  // columns c-2 (0..2) and c-1 (3..5): u, m, l
    int                           row_phase;
    int                           col;
    logic [sobel_pkg::LINE_W-1:0] line_width;
    logic                         x_mode;
    int                           errors = 0;

    function automatic logic [sobel_pkg::PIX_W-1:0] clamp_pixel(input int t);
        if (t < 0) return '0;
        if (t > 255) return '1;
        return t[sobel_pkg::PIX_W-1:0];
    endfunction

    // 3x3 kernel: left and centre columns from the window, right column passed in
    function automatic logic [sobel_pkg::PIX_W-1:0] sobel_kernel(
        input logic [sobel_pkg::PIX_W-1:0] r0,
        input logic [sobel_pkg::PIX_W-1:0] r1,
        input logic [sobel_pkg::PIX_W-1:0] r2);
        int t;
        if (x_mode) begin
            t = -int'(win[0]) + int'(r0) - 2 * int'(win[1]) + 2 * int'(r1)
                - int'(win[2]) + int'(r2);
            if (t < 0) t = -t;
        end else begin
            t = -int'(win[0]) + int'(win[2]) - 2 * int'(win[3]) + 2 * int'(win[5])
                - int'(r0) + int'(r2);
        end
        return clamp_pixel(t);
    endfunction

    task automatic reset_filter();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 6; i++) win[i] = '0;
        row_phase  = 0;
        col        = 0;
        line_width = sobel_pkg::LINE_W'(sobel_pkg::DEFAULT_LINE_WIDTH);
        x_mode     = 1'b1;
    endtask

    // one accepted pixel: update line stores and window, queue the results it causes
    task automatic filter_pixel(input logic [sobel_pkg::PIX_W-1:0] pix);
        int                          w;
        int                          c;
        int                          idx;
        logic [sobel_pkg::PIX_W-1:0] r0;
        logic [sobel_pkg::PIX_W-1:0] r1;
        bit                          last;
        t_result                     res;
        w = int'(line_width);
        if (w < sobel_pkg::MIN_LINE_WIDTH) w = sobel_pkg::MIN_LINE_WIDTH;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        c   = col;
        idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
        r0  = upper_row[idx];
        r1  = middle_row[idx];
        upper_row[idx]  = r1;
        middle_row[idx] = pix;
        last = (c >= w - 1);
        if (row_phase >= 1 && c >= 1) begin
            res.pixel    = '0;
            res.line_end = 1'b0;
            if (row_phase >= 2 && c >= 2) res.pixel = sobel_kernel(r0, r1, pix);
            expected_q.push_back(res);
        end
        // extra last-column result closes the output line
        if (row_phase >= 1 && last) begin
            res.pixel    = '0;
            res.line_end = 1'b1;
            expected_q.push_back(res);
        end
        for (int i = 0; i < 3; i++) win[i] = win[i + 3];
        win[3] = r0;
        win[4] = r1;
        win[5] = pix;
        if (last) begin
            col = 0;
            if (row_phase < 2) row_phase++;
        end else begin
            col = (c + 1) & 'h7FF;
        end
    endtask

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            reset_filter();
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == sobel_pkg::CFG_LINE_WIDTH) line_width = i_cfg_data;
                else if (i_cfg_index == sobel_pkg::CFG_X_MODE) x_mode = i_cfg_data[0];
            end
            if (i_in_valid && i_in_ready) filter_pixel(i_pixel_in);
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction: pixel_out %0d line_end %0d",
                           i_pixel_out, i_line_end);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_pixel_out !== want.pixel) begin
                        $error("pixel_out: expected %0d, actual %0d", want.pixel, i_pixel_out);
                        errors++;
                    end
                    if (i_line_end !== want.line_end) begin
                        $error("line_end: expected %0d, actual %0d", want.line_end, i_line_end);
                        errors++;
                    end
                end
            end
        end
        o_err_count <= errors;
        o_pending   <= expected_q.size();
    end

endmodule

/* tb/sobel_line_edge_filter_test.sv */
// Top of the edge filter testbench: clock, reset, stimulus, receiver, watchdog and verdict.
module sobel_line_edge_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH     = 1024;
    localparam int FILL_WIDTH    = 200;
    localparam int RANDOM_ITEMS  = 870;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AT_FIRST = 100;
    localparam int HOLD_AT_LATER = 700;
    // index with no register behind it
    localparam logic [sobel_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_in_valid  = 1'b0;
    logic [sobel_pkg::PIX_W-1:0]     i_pixel_in  = '0;
    logic                            i_out_ready = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [sobel_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [sobel_pkg::LINE_W-1:0]    i_cfg_data  = '0;
    logic                            o_in_ready;
    logic                            o_out_valid;
    logic [sobel_pkg::PIX_W-1:0]     o_pixel_out;
    logic                            o_line_end;
    logic                            o_cfg_ready;
    int                              err_count;
    int                              pending;

    // sender bookkeeping
    int cur_col       = 0;
    int eff_w         = sobel_pkg::DEFAULT_LINE_WIDTH;
    int items_sent    = 0;
    bit sender_steady = 1'b0;
    int stall_cycles  = 0;

    always #2 i_clk = ~i_clk;

    sobel_line_edge_filter #(.MAX_WIDTH(MAX_WIDTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .o_line_end  (o_line_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sobel_line_edge_filter_check #(.MAX_WIDTH(MAX_WIDTH)) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_pixel_in  (i_pixel_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_pixel_out (o_pixel_out),
        .i_line_end  (o_line_end),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // pixels biased towards the clamp extremes
    function automatic logic [sobel_pkg::PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return sobel_pkg::PIX_W'($urandom);
    endfunction

    // x_mode word with junk in the unused upper bits
    function automatic logic [sobel_pkg::LINE_W-1:0] mode_word(input logic m);
        logic [sobel_pkg::LINE_W-1:0] d;
        d    = sobel_pkg::LINE_W'($urandom);
        d[0] = m;
        return d;
    endfunction

    task automatic send_pixel(input logic [sobel_pkg::PIX_W-1:0] pix);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (cur_col >= eff_w - 1) cur_col = 0;
        else cur_col++;
    endtask

    // complete the current line with random pixels
    task automatic finish_line();
        int n;
        n = (cur_col < eff_w) ? eff_w - cur_col : 1;
        repeat (n) send_pixel(pick_pixel());
    endtask

    task automatic send_line3(input logic [sobel_pkg::PIX_W-1:0] a,
                              input logic [sobel_pkg::PIX_W-1:0] b,
                              input logic [sobel_pkg::PIX_W-1:0] c);
        send_pixel(a);
        send_pixel(b);
        send_pixel(c);
    endtask

    // stop offering, let every owed result drain, then allow for pixels with no result
    task automatic wait_idle();
        @(negedge i_clk) i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sobel_pkg::LINE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        if (idx == sobel_pkg::CFG_LINE_WIDTH) begin
            eff_w = int'(data);
            if (eff_w < sobel_pkg::MIN_LINE_WIDTH) eff_w = sobel_pkg::MIN_LINE_WIDTH;
            if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
        end
    endtask

    // stimulus
    initial begin
        int target;
        int r;
        int w;
        int rows;
        int part;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // fill both line stores over the widest line used later
        write_reg(sobel_pkg::CFG_LINE_WIDTH, sobel_pkg::LINE_W'(FILL_WIDTH));
        write_reg(sobel_pkg::CFG_X_MODE, mode_word(1'b1));
        sender_steady = 1'b1;
        finish_line();
        sender_steady = 1'b0;
        finish_line();

        // horizontal derivative at the narrowest line, width below range
        wait_idle();
        write_reg(sobel_pkg::CFG_LINE_WIDTH, 11'd0);
        write_reg(sobel_pkg::CFG_X_MODE, mode_word(1'b1));
        write_reg(CFG_UNUSED, '1);
        send_line3(8'd0, 8'd128, 8'd255);
        send_line3(8'd0, 8'd128, 8'd255);
        send_line3(8'd0, 8'd128, 8'd255);
        send_line3(8'd255, 8'd128, 8'd0);

        // vertical derivative: one row clamps low, the next clamps high
        wait_idle();
        write_reg(sobel_pkg::CFG_LINE_WIDTH, 11'd1);
        write_reg(sobel_pkg::CFG_X_MODE, mode_word(1'b0));
        send_line3(8'd0, 8'd0, 8'd0);
        send_line3(8'd255, 8'd255, 8'd255);

        // shrink the width part-way through a line
        wait_idle();
        write_reg(sobel_pkg::CFG_LINE_WIDTH, 11'd24);
        repeat (10) send_pixel(pick_pixel());
        wait_idle();
        write_reg(sobel_pkg::CFG_LINE_WIDTH, 11'd2);
        finish_line();

        // random phases of whole lines, now and then a broken one
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            wait_idle();
            r = $urandom_range(0, 9);
            if (r == 0) w = $urandom_range(0, 2);
            else if (r == 1) w = $urandom_range(60, FILL_WIDTH);
            else w = $urandom_range(3, 24);
            write_reg(sobel_pkg::CFG_LINE_WIDTH, w[sobel_pkg::LINE_W-1:0]);
            write_reg(sobel_pkg::CFG_X_MODE, mode_word(1'($urandom_range(0, 1))));
            sender_steady = ($urandom_range(0, 3) == 0);
            rows = $urandom_range(1, 5);
            // keep the total close to the item budget
            while (rows > 1 && rows * eff_w > target - items_sent) rows--;
            repeat (rows) finish_line();
            if ($urandom_range(0, 5) == 0) begin
                part = $urandom_range(1, eff_w - 1);
                repeat (part) send_pixel(pick_pixel());
            end
        end

        wait_idle();
        if (err_count == 0 && pending == 0) begin
            $display("sobel_line_edge_filter_test: clean");
        end else begin
            $display("sobel_line_edge_filter_test: errors");
        end
        $finish;
    end

    // result receiver with random stalls and two long hold-offs
    initial begin
        int gap;
        int results_taken;
        bit steady;
        results_taken = 0;
        steady        = 1'b0;
        wait (i_rst_n);
        forever begin
            if (results_taken == HOLD_AT_FIRST || results_taken == HOLD_AT_LATER) begin
                repeat (HOLD_CYCLES) @(negedge i_clk) i_out_ready <= 1'b0;
            end
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                @(negedge i_clk) i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_taken++;
            if (results_taken % 97 == 0) steady = 1'($urandom_range(0, 1));
        end
    end

    // watchdog: cycles without any transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("sobel_line_edge_filter_test: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

/* filelist.f */
sv/sobel_pkg.sv
sv/sobel_ram.sv
sv/sobel_line_edge_filter.sv
tb/sobel_line_edge_filter_check.sv
tb/sobel_line_edge_filter_test.sv
